[hdl/gds_pkg.sv]
// Shared constants, types and state codes for the gcd downward search block.
package gds_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned SHIFT_WIDTH = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] gds_word_t;
  typedef logic [SHIFT_WIDTH-1:0] gds_shift_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } gds_state_e;

  // Sequencer to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } gds_ctl_t;

  // Datapath to sequencer status
  typedef struct packed {
    logic fin;
  } gds_stat_t;

endpackage

[hdl/gds_ctrl.sv]
// Sequencer: loads operands, steps the shared unit until one operand is zero, issues the strobe.
module gds_ctrl import gds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  gds_stat_t stat_i,
  output gds_ctl_t  ctl_o,
  output logic      busy_o,
  output logic      done_o
);

  gds_state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance the sequence and drive datapath commands
  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    busy_o      = 1'b1;
    done_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat_i.fin) begin
          ctl_o.capture = 1'b1;
          state_d       = ST_DONE;
        end else begin
          ctl_o.step = 1'b1;
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/gds_datapath.sv]
// Operand registers and the shared compare/subtract/shift unit of a binary gcd.
module gds_datapath import gds_pkg::*; (
  input  logic                         clk_i,
  input  gds_ctl_t                     ctl_i,
  input  logic signed [DATA_WIDTH-1:0] first_value_i,
  input  logic signed [DATA_WIDTH-1:0] second_value_i,
  output gds_stat_t                    stat_o,
  output gds_word_t                    divisor_o
);

  gds_word_t  a_q, a_d;
  gds_word_t  b_q, b_d;
  gds_shift_t k_q, k_d;
  logic       eq_q, eq_d;
  gds_word_t  result_q;

  gds_word_t  mag_a, mag_b;
  logic       ge;
  gds_word_t  hi, lo, diff;
  gds_word_t  fin_val;
  gds_word_t  result_d;

  // Take magnitudes; the most negative value maps to 2^(DATA_WIDTH-1)
  assign mag_a = first_value_i[DATA_WIDTH-1]  ? (~first_value_i + gds_word_t'(1))
                                              : gds_word_t'(first_value_i);
  assign mag_b = second_value_i[DATA_WIDTH-1] ? (~second_value_i + gds_word_t'(1))
                                              : gds_word_t'(second_value_i);

  // Shared unit: compare, then subtract smaller from larger
  assign ge   = (a_q >= b_q);
  assign hi   = ge ? a_q : b_q;
  assign lo   = ge ? b_q : a_q;
  assign diff = hi - lo;

  // Finish once either operand is zero; restore the common power of two
  assign stat_o.fin = (a_q == '0) || (b_q == '0);
  assign fin_val    = (a_q | b_q) << k_q;
  assign result_d   = (eq_q || (fin_val > gds_word_t'(1))) ? fin_val : '0;

  // Select the next operand values
  always_comb begin
    a_d  = a_q;
    b_d  = b_q;
    k_d  = k_q;
    eq_d = eq_q;
    if (ctl_i.load) begin
      a_d  = mag_a;
      b_d  = mag_b;
      k_d  = '0;
      eq_d = (first_value_i == second_value_i);
    end else if (ctl_i.step) begin
      priority if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + gds_shift_t'(1);
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (ge) begin
        a_d = diff;
      end else begin
        b_d = diff;
      end
    end
  end

  // Hold operands
  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    b_q  <= b_d;
    k_q  <= k_d;
    eq_q <= eq_d;
  end

  // Hold the result for the strobe cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      result_q <= result_d;
    end
  end

  assign divisor_o = result_q;

endmodule

[hdl/gcd_downward_search_top.sv]
// Top level of the gcd downward search block: sequencer plus shared datapath.
//
// Usage: drive first_value_i and second_value_i (signed) and raise start_i;
// a transfer in happens at the rising edge where start_i is high and busy_o
// is low. busy_o stays high until the result has been presented.
// The result appears on divisor_o for exactly one cycle, marked by done_o;
// the receiver takes it at the edge ending that cycle and cannot stall it.
// divisor_o is the greatest common divisor of the operand magnitudes, 0 when
// the operands are coprime, and the magnitude itself when both are equal.
// Sequence: a load, then the binary-gcd steps of the single shared
// compare/subtract/shift unit (a halving or one subtraction each), then a
// capture and the strobe; a new item is taken the cycle after done_o.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// any item in flight; no result is issued for it.
module gcd_downward_search_top import gds_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [DATA_WIDTH-1:0] first_value_i,
  input  logic signed [DATA_WIDTH-1:0] second_value_i,
  output logic                         done_o,
  output logic        [DATA_WIDTH-1:0] divisor_o
);

  gds_ctl_t  ctl;
  gds_stat_t stat;

  gds_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctl_o   (ctl),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  gds_datapath u_datapath (
    .clk_i          (clk_i),
    .ctl_i          (ctl),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .stat_o         (stat),
    .divisor_o      (divisor_o)
  );

endmodule

[verif/tb.sv]
// Self-checking testbench for the gcd downward search block.
module tb;
  import gds_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned ITEMS_PER_PHASE = 385;
  localparam gds_word_t MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam gds_word_t MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // Expected divisors, oldest first, with the operands that produced them
  typedef struct {
    gds_word_t first;
    gds_word_t second;
    gds_word_t divisor;
  } gcd_case_t;

  class divisor_tracker;
    gcd_case_t pending_divisors[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function gds_word_t magnitude_of(gds_word_t v);
      return v[DATA_WIDTH-1] ? gds_word_t'(~v + 1'b1) : v;
    endfunction

    // Euclid on the magnitudes; equal operands give the magnitude, gcd of 1 gives 0
    function gds_word_t expected_divisor(gds_word_t a, gds_word_t b);
      gds_word_t x;
      gds_word_t y;
      gds_word_t r;
      if (a == b) return magnitude_of(a);
      x = magnitude_of(a);
      y = magnitude_of(b);
      while (y != '0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return (x < 2) ? '0 : x;
    endfunction

    function void note_operands(gds_word_t a, gds_word_t b);
      gcd_case_t c;
      c.first = a;
      c.second = b;
      c.divisor = expected_divisor(a, b);
      pending_divisors.push_back(c);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 40) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_divisor(gds_word_t got);
      gcd_case_t c;
      if (pending_divisors.size() == 0) begin
        report_mismatch($sformatf("divisor %0h with no transfer pending", got));
      end else begin
        c = pending_divisors.pop_front();
        if (got !== c.divisor)
          report_mismatch($sformatf("operands %0h %0h: divisor %0h, want %0h",
                                    c.first, c.second, got, c.divisor));
      end
    endtask
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  gds_word_t first_value_i = '0;
  gds_word_t second_value_i = '0;
  logic      busy_o;
  logic      done_o;
  gds_word_t divisor_o;

  divisor_tracker tracker = new();
  int unsigned idle_pct = 0;
  int unsigned cycle_count = 0;

  gcd_downward_search_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .done_o         (done_o),
    .divisor_o      (divisor_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Check every strobed divisor against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_divisor(divisor_o);
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Offer one operand pair and hold it until the block takes the transfer
  task send_operands(gds_word_t a, gds_word_t b);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    first_value_i <= a;
    second_value_i <= b;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    tracker.note_operands(a, b);
  endtask

  // Hold off the sender until every expected divisor has come back
  task wait_drained();
    start_i <= 1'b0;
    while (tracker.pending_divisors.size() != 0) @(posedge clk_i);
  endtask

  function gds_word_t maybe_negate(gds_word_t v);
    return $urandom_range(1) ? gds_word_t'(-v) : v;
  endfunction

  // Pick one random operand pair, weighted toward pairs with a shared factor
  task send_random_pair();
    gds_word_t a;
    gds_word_t b;
    gds_word_t g;
    gds_word_t lim;
    case ($urandom_range(10))
      0, 1: begin
        a = $urandom;
        b = $urandom;
      end
      2, 3, 4, 5: begin
        g = $urandom >> $urandom_range(30, 1);
        if (g == '0) g = 1;
        lim = MOST_POS / g;
        a = maybe_negate(g * $urandom_range(lim, 0));
        b = maybe_negate(g * $urandom_range(lim, 0));
      end
      6: begin
        a = $urandom >> $urandom_range(31, 0);
        a = maybe_negate(a);
        b = a;
      end
      7: begin
        a = $urandom;
        b = -a;
      end
      8: begin
        a = $urandom >> $urandom_range(31, 0);
        a = maybe_negate(a);
        b = '0;
        if ($urandom_range(1)) begin
          b = a;
          a = '0;
        end
      end
      9: begin
        a = gds_word_t'($urandom_range(128)) - 64;
        b = gds_word_t'($urandom_range(128)) - 64;
      end
      default: begin
        a = maybe_negate(($urandom >> $urandom_range(31, 8)) << $urandom_range(20, 0));
        b = maybe_negate(($urandom >> $urandom_range(31, 8)) << $urandom_range(20, 0));
      end
    endcase
    send_operands(a, b);
  endtask

  initial begin
    int unsigned phase_idle[4];
    phase_idle = '{0, 77, 0, 34};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: equal, zero, coprime, opposite and most negative operands
    send_operands(0, 0);
    send_operands(1, 1);
    send_operands(-1, -1);
    send_operands(0, 5);
    send_operands(0, 1);
    send_operands(0, -1);
    send_operands(-36, 0);
    send_operands(12, 18);
    send_operands(-12, 18);
    send_operands(48, -180);
    send_operands(7, 13);
    send_operands(1, -1);
    send_operands(15, -15);
    send_operands(MOST_NEG, 0);
    send_operands(0, MOST_NEG);
    send_operands(MOST_NEG, MOST_NEG);
    send_operands(MOST_NEG, MOST_POS);
    send_operands(MOST_POS, MOST_POS);
    send_operands(MOST_POS, -MOST_POS);
    send_operands(MOST_NEG, 32'h4000_0000);
    send_operands(MOST_NEG, 32'hc000_0000);
    send_operands(32'h4000_0000, 32'h6000_0000);
    send_operands(32'hffff_ffff, MOST_POS);
    wait_drained();

    // Random phases with different sender idling, draining between them
    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      repeat (ITEMS_PER_PHASE) send_random_pair();
      idle_pct = 0;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
